>>> rtl/core/sbs_pkg.sv
// Shared types and constants for the sorted-table binary search core.
// Field widths, transaction kind codes and default table depth.
// No dependencies.
package sbs_pkg;

    // Payload field widths
    localparam int IDX_W = 10;
    localparam int VAL_W = 32;
    localparam int CNT_W = 11;

    // Default table depth
    localparam int TABLE_DEPTH_DEF = 1024;

    // Transaction kind codes
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    typedef logic [IDX_W-1:0]        t_index;
    typedef logic signed [VAL_W-1:0] t_value;
    typedef logic [CNT_W-1:0]        t_count;

endpackage

>>> rtl/core/sbs_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on sbs_pkg for the payload types.
interface sbs_in_if;
    import sbs_pkg::*;

    logic   valid;
    logic   ready;
    logic   kind;
    t_index entry_index;
    t_value entry_value;
    t_value search_key;

    modport source (output valid, kind, entry_index, entry_value, search_key,
                    input ready);
    modport sink   (input valid, kind, entry_index, entry_value, search_key,
                    output ready);
endinterface

interface sbs_out_if;
    logic valid;
    logic ready;
    logic found;

    modport source (output valid, found, input ready);
    modport sink   (input valid, found, output ready);
endinterface

>>> rtl/core/sbs_table_mem.sv
// Table storage: one write port, one read port with registered read data.
// Depends on sbs_pkg for the entry type.
module sbs_table_mem #(
    parameter int TABLE_DEPTH = sbs_pkg::TABLE_DEPTH_DEF,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  sbs_pkg::t_value i_wr_data,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output sbs_pkg::t_value o_rd_data
);
    import sbs_pkg::*;

    t_value r_mem [TABLE_DEPTH];
    t_value r_rd_data;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one entry into the registered read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/sbs_ctrl.sv
// Search sequencer: takes load and search transactions, drives the table
// memory, narrows the live range one probe per cycle and registers the result.
// Depends on sbs_pkg and the sbs_in_if / sbs_out_if interfaces.
module sbs_ctrl #(
    parameter int TABLE_DEPTH = sbs_pkg::TABLE_DEPTH_DEF,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sbs_in_if.sink          i_in,
    sbs_out_if.source       o_out,
    input  logic            i_cfg_we,
    input  sbs_pkg::t_count i_cfg_wdata,
    output logic            o_wr_en,
    output logic [AW-1:0]   o_wr_addr,
    output sbs_pkg::t_value o_wr_data,
    output logic            o_rd_en,
    output logic [AW-1:0]   o_rd_addr,
    input  sbs_pkg::t_value i_rd_data
);
    import sbs_pkg::*;

    localparam int XW = (AW > CNT_W) ? AW : CNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_HOLD
    } t_state;

    t_state  r_state, n_state;
    t_count  r_entry_count;
    t_count  r_lo, n_lo;
    t_count  r_hi, n_hi;
    t_count  r_mid;
    t_value  r_key, n_key;
    logic    r_hold_found, n_hold_found;
    logic    r_out_valid, n_out_valid;
    logic    r_out_found;

    logic    in_acc;
    logic    slot_free;
    logic    launch;
    logic    res_now;
    logic    res_found;
    logic    out_load;
    logic    out_found;
    logic    live;
    t_count  p_mid;
    t_count  count_clamp;
    logic [XW-1:0] mid_x;
    logic [XW-1:0] idx_x;

    assign in_acc    = i_in.valid && i_in.ready;
    assign slot_free = !r_out_valid || o_out.ready;

    // Clamp the entry count to the table depth
    assign count_clamp = (32'(r_entry_count) > TABLE_DEPTH)
                       ? CNT_W'(TABLE_DEPTH) : r_entry_count;

    // Load path: write straight into the table
    assign idx_x     = XW'(i_in.entry_index);
    assign o_wr_en   = in_acc && (i_in.kind == KIND_LOAD)
                     && (32'(i_in.entry_index) < TABLE_DEPTH);
    assign o_wr_addr = idx_x[AW-1:0];
    assign o_wr_data = i_in.entry_value;

    // Range update, next probe and result
    always_comb begin
        n_state      = r_state;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_key        = r_key;
        n_hold_found = r_hold_found;
        launch       = 1'b0;
        res_now      = 1'b0;
        res_found    = 1'b0;
        out_load     = 1'b0;
        out_found    = 1'b0;
        o_rd_en      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in.kind == KIND_SEARCH)) begin
                    n_key  = i_in.search_key;
                    n_lo   = '0;
                    n_hi   = count_clamp;
                    launch = 1'b1;
                end
            end
            S_CMP: begin
                if (i_rd_data == r_key) begin
                    res_now   = 1'b1;
                    res_found = 1'b1;
                end else if (i_rd_data < r_key) begin
                    n_lo   = r_mid + 1'b1;
                    launch = 1'b1;
                end else begin
                    n_hi   = r_mid;
                    launch = 1'b1;
                end
            end
            S_HOLD: begin
                if (slot_free) begin
                    out_load  = 1'b1;
                    out_found = r_hold_found;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        p_mid = n_lo + ((n_hi - n_lo) >> 1);
        live  = n_lo < n_hi;

        // Issue the next probe, or finish when the range is empty
        if (launch) begin
            if (live) begin
                o_rd_en = 1'b1;
                n_state = S_CMP;
            end else begin
                res_now   = 1'b1;
                res_found = 1'b0;
            end
        end

        // Deliver the result, or hold it while the output is busy
        if (res_now) begin
            if (slot_free) begin
                out_load  = 1'b1;
                out_found = res_found;
                n_state   = S_IDLE;
            end else begin
                n_hold_found = res_found;
                n_state      = S_HOLD;
            end
        end

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign mid_x     = XW'(p_mid);
    assign o_rd_addr = mid_x[AW-1:0];

    // State, range and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_entry_count <= '0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_lo         <= n_lo;
            r_hi         <= n_hi;
            r_key        <= n_key;
            r_hold_found <= n_hold_found;
            if (o_rd_en) begin
                r_mid <= p_mid;
            end
            if (out_load) begin
                r_out_found <= out_found;
            end
            if (i_cfg_we) begin
                r_entry_count <= i_cfg_wdata;
            end
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.found = r_out_found;

`ifndef NO_ASSERTIONS
    // A probe in flight always has a live range
    a_live_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_lo < r_hi))
        else $error("probe without live range");

    // The probed entry lies inside the live range
    a_mid_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> ((r_mid >= r_lo) && (r_mid < r_hi)))
        else $error("probe outside live range");

    // A held result only waits behind an occupied output register
    a_hold_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD) |-> r_out_valid)
        else $error("result held with free output");

    // A search over a non-empty table starts probing at once
    a_search_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.kind == KIND_SEARCH) && (count_clamp != '0))
        |=> (r_state == S_CMP))
        else $error("search did not start probing");
`endif

endmodule

>>> rtl/core/sorted_table_binary_search_core.sv
// Sorted-table binary search core: one table memory and a search sequencer.
// Load transaction: written in the cycle it is accepted; ready again next cycle.
// Search transaction: one probe per cycle on the single memory read port, at most
// floor(log2(min(entry_count, TABLE_DEPTH))) + 1 probes (11 for 1024 entries);
// the result is registered for output, and no new transaction is accepted until it is.
// Synchronous active-low reset clears control state and entry_count; the table is not cleared.
module sorted_table_binary_search_core #(
    parameter int TABLE_DEPTH = sbs_pkg::TABLE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sbs_in_if.sink          i_in,
    sbs_out_if.source       o_out,
    input  logic            i_cfg_we,
    input  sbs_pkg::t_count i_cfg_wdata
);
    import sbs_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_value        wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_value        rd_data;

    // Search sequencer and output register
    sbs_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    // Sorted table storage
    sbs_table_mem #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

>>> bench/tb_sorted_table_binary_search_core.sv
// Self-checking bench for sorted_table_binary_search_core: table loads, searches and count writes.
// Depends on sbs_pkg, sbs_in_if and sbs_out_if from the RTL; drives and checks the
// valid/ready channels against an in-bench binary search over a mirrored table.
`timescale 1ns / 1ps

module tb_sorted_table_binary_search_core;
    import sbs_pkg::*;

    localparam int TABLE_DEPTH   = TABLE_DEPTH_DEF;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int LATENCY_SLACK = 20;
    localparam int PHASE_ITEMS   = 12;
    localparam int NUM_PHASES    = 12;
    localparam int RANDOM_COUNT  = -1;
    localparam int LONG_HOLD     = 400;

    localparam t_value VALUE_MIN = 32'h8000_0000;
    localparam t_value VALUE_MAX = 32'h7fff_ffff;

    // Idle percentages per idling mode: none, sender, receiver, both
    localparam int SEND_IDLE[4]  = '{0, 63, 0, 38};
    localparam int RECV_STALL[4] = '{0, 0, 63, 38};

    // Entry counts per random phase, extremes included
    localparam int PHASE_COUNTS[NUM_PHASES] = '{1024, 2047, 1, 2, 3, 0, 1023, 1025,
                                                512, RANDOM_COUNT, RANDOM_COUNT, 1024};

    typedef struct {
        logic   kind;
        t_index entry_index;
        t_value entry_value;
        t_value search_key;
    } table_op_t;

    typedef struct {
        t_value key;
        logic   found;
    } found_check_t;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   cfg_we;
    t_count cfg_wdata;

    sbs_in_if  req_if ();
    sbs_out_if rsp_if ();

    sorted_table_binary_search_core #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (req_if),
        .o_out       (rsp_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // Stimulus side
    table_op_t    pending_ops [$];
    t_value       plan_table [TABLE_DEPTH];
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    int           hold_len       = 0;
    int           hold_token     = 0;

    // Receiver hold-off bookkeeping
    int           hold_token_seen = 0;
    int           hold_left       = 0;

    // Predictor state and expected results
    t_value       mirror_table [TABLE_DEPTH];
    t_count       mirror_count;
    found_check_t pending_found [$];
    logic         req_taken = 1'b0;
    int           error_count = 0;
    int           cycle_count = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Binary search over the mirrored table, halving the live range each probe
    function automatic logic lookup_key(t_value key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = (mirror_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(mirror_count);
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (mirror_table[mid] == key)
                return 1'b1;
            if (mirror_table[mid] < key)
                lo = mid + 1;
            else
                hi = mid;
        end
        return 1'b0;
    endfunction

    // Bias keys towards live entries and their immediate neighbours
    function automatic t_value pick_search_key(int live);
        int r;
        int idx;
        r = $urandom_range(0, 99);
        if (live == 0 || r < 15)
            return t_value'($urandom);
        idx = $urandom_range(0, live - 1);
        if (r < 65)
            return plan_table[idx];
        if (r < 75)
            return plan_table[idx] + 1;
        if (r < 85)
            return plan_table[idx] - 1;
        if (r < 92)
            return VALUE_MIN;
        return VALUE_MAX;
    endfunction

    // Pick a value that keeps the planned table in ascending order
    function automatic t_value between_neighbours(int idx);
        longint lo_v;
        longint hi_v;
        longint span;
        lo_v = (idx == 0) ? longint'(VALUE_MIN) : longint'(plan_table[idx-1]);
        hi_v = (idx == TABLE_DEPTH - 1) ? longint'(VALUE_MAX) : longint'(plan_table[idx+1]);
        if (hi_v < lo_v)
            return plan_table[idx];
        span = hi_v - lo_v;
        return t_value'(lo_v + longint'({$urandom, $urandom} % longint'(span + 1)));
    endfunction

    task automatic queue_load(int idx, t_value val);
        pending_ops.insert(pending_ops.size(),
                           '{kind: KIND_LOAD, entry_index: t_index'(idx),
                             entry_value: val, search_key: t_value'($urandom)});
        plan_table[idx] = val;
    endtask

    task automatic queue_search(t_value key);
        pending_ops.insert(pending_ops.size(),
                           '{kind: KIND_SEARCH, entry_index: t_index'($urandom),
                             entry_value: t_value'($urandom), search_key: key});
    endtask

    // Hold until every queued transaction is taken and every result is back
    task automatic wait_until_idle();
        do begin
            @(posedge clk);
            #1;
        end while (pending_ops.size() != 0 || req_if.valid || pending_found.size() != 0);
        repeat (LATENCY_SLACK) @(posedge clk);
    endtask

    task automatic write_entry_count(t_count value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_idling(int mode);
        send_idle_pct  = SEND_IDLE[mode];
        recv_stall_pct = RECV_STALL[mode];
    endtask

    // Request driver: present the next transaction once the current one is taken
    always @(negedge clk) begin : drive_requests
        table_op_t op;
        if (!rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_taken) begin
            if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                op = pending_ops.pop_front();
                req_if.valid       <= 1'b1;
                req_if.kind        <= op.kind;
                req_if.entry_index <= op.entry_index;
                req_if.entry_value <= op.entry_value;
                req_if.search_key  <= op.search_key;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off when requested
    always @(negedge clk) begin : drive_ready
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (hold_token != hold_token_seen) begin
                hold_token_seen = hold_token;
                hold_left       = hold_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Monitor: check results first, then record the accepted request and register writes
    always @(posedge clk) begin : watch_channels
        found_check_t exp;
        if (!rst_n) begin
            req_taken    = 1'b0;
            mirror_count = '0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (pending_found.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got found=%0b",
                             $time, rsp_if.found);
                    error_count++;
                end else begin
                    exp = pending_found.pop_front();
                    if (rsp_if.found !== exp.found) begin
                        $display("%0t: search for key %0d: expected found=%0b, got found=%0b",
                                 $time, exp.key, exp.found, rsp_if.found);
                        error_count++;
                    end
                end
            end
            req_taken = req_if.valid && req_if.ready;
            if (req_taken) begin
                if (req_if.kind == KIND_LOAD)
                    mirror_table[req_if.entry_index] = req_if.entry_value;
                else
                    pending_found.insert(pending_found.size(),
                                         '{key: req_if.search_key,
                                           found: lookup_key(req_if.search_key)});
            end
            if (cfg_we)
                mirror_count = cfg_wdata;
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : run_phases
        int     ph;
        int     n;
        int     r;
        int     idx;
        int     count;
        int     live;
        logic [31:0] raw;
        int     restore_idx [$];
        t_value restore_val [$];

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        req_if.valid       = 1'b0;
        req_if.kind        = KIND_LOAD;
        req_if.entry_index = '0;
        req_if.entry_value = '0;
        req_if.search_key  = '0;
        rsp_if.ready       = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty table: every search misses, nothing is read
        set_idling(0);
        queue_search('0);
        queue_search(VALUE_MIN);
        queue_search(VALUE_MAX);
        // Load the value extremes and the index extremes
        queue_load(0, VALUE_MIN);
        queue_load(1, VALUE_MAX);
        queue_load(TABLE_DEPTH - 1, '0);
        queue_load(512, -1);
        wait_until_idle();

        // Single entry
        write_entry_count(t_count'(1));
        queue_search(VALUE_MIN);
        queue_search(VALUE_MAX);
        queue_search('0);
        wait_until_idle();

        // Two entries, then swap them so the search misses a present key
        write_entry_count(t_count'(2));
        queue_search(VALUE_MIN);
        queue_search(VALUE_MAX);
        queue_search(-1);
        queue_load(0, VALUE_MAX);
        queue_load(1, VALUE_MIN);
        queue_search(VALUE_MIN);
        queue_search(VALUE_MAX);
        wait_until_idle();

        // Fill the whole table in ascending order, a few duplicates, some searches between
        set_idling(3);
        for (idx = 0; idx < TABLE_DEPTH; idx++) begin
            raw = 32'h8000_0000 + 32'(idx) * 32'h0040_0000;
            if (idx == TABLE_DEPTH - 1)
                raw += 32'h003f_ffff;
            else if (idx != 0)
                raw += $urandom & 32'h003f_ffff;
            if (idx > 0 && idx < TABLE_DEPTH - 1 && $urandom_range(0, 7) == 0)
                queue_load(idx, plan_table[idx-1]);
            else
                queue_load(idx, t_value'(raw));
            if ($urandom_range(0, 31) == 0)
                queue_search(pick_search_key(2));
        end

        // Random phases over several entry counts and idling modes
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            wait_until_idle();
            count = (PHASE_COUNTS[ph] == RANDOM_COUNT) ?
                    $urandom_range(4, TABLE_DEPTH - 2) : PHASE_COUNTS[ph];
            write_entry_count(t_count'(count));
            set_idling(ph % 4);
            // Stall the result side long enough for the input to back up
            if (ph == 0) begin
                hold_len = LONG_HOLD;
                hold_token++;
            end
            live = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 78) begin
                    queue_search(pick_search_key(live));
                end else if (r < 95 || live == 0) begin
                    idx = $urandom_range(0, TABLE_DEPTH - 1);
                    queue_load(idx, between_neighbours(idx));
                end else begin
                    // Disturb the order for a while, restore at the end of the phase
                    idx = $urandom_range(0, live - 1);
                    restore_idx.push_front(idx);
                    restore_val.push_front(plan_table[idx]);
                    queue_load(idx, t_value'($urandom));
                end
            end
            while (restore_idx.size() != 0)
                queue_load(restore_idx.pop_front(), restore_val.pop_front());
        end

        wait_until_idle();
        if (error_count == 0 && pending_found.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
